/* design/npcs_pkg.sv */
// Shared types, constants and palette tables for the nearest palette color search.
package npcs_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 22;
  localparam int unsigned BestW = 24;

  localparam logic [BestW-1:0] DistStart      = 24'hffffff;
  localparam logic [DistW-1:0] DistGoodEnough = 22'd31;
  localparam logic [7:0]       SysCount       = 8'h10;
  localparam logic [7:0]       CubeLast       = 8'he7;
  localparam logic [7:0]       GreyFirst      = 8'he8;
  localparam logic [7:0]       SkipA          = 8'd16;
  localparam logic [7:0]       SkipB          = 8'd231;
  localparam logic [7:0]       LastIdx        = 8'd255;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic init;
    logic step;
  } gen_ctrl_t;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  function automatic logic [ChanW-1:0] cube_level(input logic [2:0] k);
    logic [ChanW-1:0] v;
    case (k)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic rgb_t sys_color(input logic [3:0] i);
    rgb_t c;
    case (i)
      4'd0:    c = '{8'h00, 8'h00, 8'h00};
      4'd1:    c = '{8'hcd, 8'h00, 8'h00};
      4'd2:    c = '{8'h00, 8'hcd, 8'h00};
      4'd3:    c = '{8'hcd, 8'hcd, 8'h00};
      4'd4:    c = '{8'h00, 8'h00, 8'hee};
      4'd5:    c = '{8'hcd, 8'h00, 8'hcd};
      4'd6:    c = '{8'h00, 8'hcd, 8'hcd};
      4'd7:    c = '{8'he5, 8'he5, 8'he5};
      4'd8:    c = '{8'h7f, 8'h7f, 8'h7f};
      4'd9:    c = '{8'hff, 8'h00, 8'h00};
      4'd10:   c = '{8'h00, 8'hff, 8'h00};
      4'd11:   c = '{8'hff, 8'hff, 8'h00};
      4'd12:   c = '{8'h5c, 8'h5c, 8'hff};
      4'd13:   c = '{8'hff, 8'h00, 8'hff};
      4'd14:   c = '{8'h00, 8'hff, 8'hff};
      default: c = '{8'hff, 8'hff, 8'hff};
    endcase
    return c;
  endfunction

endpackage

/* design/npcs_palette.sv */
// Palette entry generator: walks indices 0..255 and produces each entry's color.
module npcs_palette import npcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  gen_ctrl_t  ctrl_i,
  output logic [7:0] idx_o,
  output rgb_t       color_o
);

  logic [7:0] idx_q, idx_d;
  logic [2:0] kr_q, kr_d, kg_q, kg_d, kb_q, kb_d;
  logic [4:0] grey_step;
  logic [7:0] grey_val;
  logic       in_cube;

  assign in_cube = (idx_q >= SysCount) && (idx_q <= CubeLast);

  always_comb begin
    idx_d = idx_q;
    kr_d  = kr_q;
    kg_d  = kg_q;
    kb_d  = kb_q;
    if (ctrl_i.init) begin
      idx_d = '0;
      kr_d  = '0;
      kg_d  = '0;
      kb_d  = '0;
    end else if (ctrl_i.step) begin
      idx_d = idx_q + 8'd1;
      if (in_cube) begin
        if (kb_q == 3'd5) begin
          kb_d = '0;
          if (kg_q == 3'd5) begin
            kg_d = '0;
            kr_d = (kr_q == 3'd5) ? 3'd0 : kr_q + 3'd1;
          end else begin
            kg_d = kg_q + 3'd1;
          end
        end else begin
          kb_d = kb_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      kr_q  <= '0;
      kg_q  <= '0;
      kb_q  <= '0;
    end else begin
      idx_q <= idx_d;
      kr_q  <= kr_d;
      kg_q  <= kg_d;
      kb_q  <= kb_d;
    end
  end

  assign grey_step = 5'(idx_q - GreyFirst);
  assign grey_val  = 8'({3'b000, grey_step} * 8'd10) + 8'd8;

  always_comb begin
    if (idx_q < SysCount) begin
      color_o = sys_color(idx_q[3:0]);
    end else if (in_cube) begin
      color_o = '{cube_level(kr_q), cube_level(kg_q), cube_level(kb_q)};
    end else begin
      color_o = '{grey_val, grey_val, grey_val};
    end
  end

  assign idx_o = idx_q;

endmodule

/* design/npcs_dist.sv */
// Weighted color distance unit: 9*dr^2 + 30*dg^2 + db^2.
module npcs_dist import npcs_pkg::*; (
  input  rgb_t             target_i,
  input  rgb_t             entry_i,
  output logic [DistW-1:0] dist_o
);

  logic [ChanW-1:0]   dr, dg, db;
  logic [2*ChanW-1:0] sr, sg, sb;

  assign dr = (target_i.r >= entry_i.r) ? target_i.r - entry_i.r : entry_i.r - target_i.r;
  assign dg = (target_i.g >= entry_i.g) ? target_i.g - entry_i.g : entry_i.g - target_i.g;
  assign db = (target_i.b >= entry_i.b) ? target_i.b - entry_i.b : entry_i.b - target_i.b;

  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;

  assign dist_o = ({6'b0, sr} * 22'd9) + ({6'b0, sg} * 22'd30) + {6'b0, sb};

endmodule

/* design/nearest_palette_color_search.sv */
// Top level: sequencer and best-match tracking for the nearest palette color search.
//
// Usage:
//   Drive red_i, green_i, blue_i and raise start; the request is taken at a
//   rising edge where start is high and busy is low. The colors are latched
//   then, so the inputs may change afterwards.
//   busy stays high while the palette is scanned, one entry per clock.
//   Entries 16 and 231 are passed over without being candidates.
//   The scan ends after entry 255, or as soon as a new best match has a
//   distance below 31.
//   done_o pulses for one cycle, registered from the cycle in which the scan
//   ends; 1 to 256 entries are walked. palette_index_o is valid only in the
//   done_o cycle.
//   No new request is taken while busy; a new request may be taken in the
//   very cycle done_o is high. The scan rate is set by the single distance
//   unit, which sees one palette entry per clock.
//   The result has no backpressure: the receiver must take it on the strobe.
//   Reset returns the block to idle with no result pending.
module nearest_palette_color_search import npcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       done_o,
  output logic [7:0] palette_index_o
);

  state_e           state_q, state_d;
  gen_ctrl_t        gen_ctrl;
  rgb_t             target_q, entry;
  logic [7:0]       idx;
  logic [DistW-1:0] entry_dist;
  logic [BestW-1:0] best_q;
  logic [7:0]       best_idx_q;
  logic             done_q;
  logic [7:0]       result_q;
  logic             accept, skip, better, finish;

  npcs_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .idx_o   (idx),
    .color_o (entry)
  );

  npcs_dist u_dist (
    .target_i (target_q),
    .entry_i  (entry),
    .dist_o   (entry_dist)
  );

  assign accept = start && (state_q == StIdle);
  assign skip   = (idx == SkipA) || (idx == SkipB);
  assign better = !skip && ({2'b00, entry_dist} < best_q);
  assign finish = (better && (entry_dist < DistGoodEnough)) || (idx == LastIdx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start) state_d = StScan;
      StScan: if (finish) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    gen_ctrl = '0;
    busy     = 1'b0;
    unique case (state_q)
      StIdle: gen_ctrl.init = start;
      StScan: begin
        gen_ctrl.step = 1'b1;
        busy          = 1'b1;
      end
      default: gen_ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StScan) && finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q   <= '{red_i, green_i, blue_i};
      best_q     <= DistStart;
      best_idx_q <= '0;
    end else if (state_q == StScan && better) begin
      best_q     <= {2'b00, entry_dist};
      best_idx_q <= idx;
    end
    if (state_q == StScan && finish) begin
      result_q <= better ? idx : best_idx_q;
    end
  end

  assign done_o          = done_q;
  assign palette_index_o = result_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while scanning");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request taken but scan not started");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("scan ended without a result");

  a_no_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (palette_index_o != SkipA) && (palette_index_o != SkipB))
    else $error("skipped entry reported");

endmodule

/* tb/nearest_palette_color_search_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the nearest palette color search block.
module nearest_palette_color_search_test;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned SysEntries    = 16;
  localparam int unsigned CubeFirstIdx  = 16;
  localparam int unsigned CubeLastIdx   = 231;
  localparam int unsigned GreyFirstIdx  = 232;
  localparam int unsigned SkipLoIdx     = 16;
  localparam int unsigned SkipHiIdx     = 231;
  localparam int unsigned RedWeight     = 9;
  localparam int unsigned GreenWeight   = 30;
  localparam int unsigned FarDist       = 24'hffffff;
  localparam int unsigned CloseDist     = 31;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic       done_o;
  logic [7:0] palette_index_o;

  logic [7:0]  expected_index_q[$];
  logic [7:0]  want_index;
  int unsigned mismatch_cnt    = 0;
  int unsigned stall_cycles    = 0;
  int unsigned sender_idle_pct = 0;

  nearest_palette_color_search i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .done_o         (done_o),
    .palette_index_o(palette_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [23:0] system_rgb(input int unsigned i);
    logic [23:0] c;
    case (i)
      0:       c = 24'h000000;
      1:       c = 24'hcd0000;
      2:       c = 24'h00cd00;
      3:       c = 24'hcdcd00;
      4:       c = 24'h0000ee;
      5:       c = 24'hcd00cd;
      6:       c = 24'h00cdcd;
      7:       c = 24'he5e5e5;
      8:       c = 24'h7f7f7f;
      9:       c = 24'hff0000;
      10:      c = 24'h00ff00;
      11:      c = 24'hffff00;
      12:      c = 24'h5c5cff;
      13:      c = 24'hff00ff;
      14:      c = 24'h00ffff;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_step(input int unsigned k);
    return (k == 0) ? 8'd0 : 8'(40 * k + 55);
  endfunction

  function automatic logic [23:0] palette_rgb(input int unsigned idx);
    int unsigned n;
    logic [7:0]  v;
    if (idx < SysEntries) begin
      return system_rgb(idx);
    end else if (idx <= CubeLastIdx) begin
      n = idx - CubeFirstIdx;
      return {cube_step((n / 36) % 6), cube_step((n / 6) % 6), cube_step(n % 6)};
    end
    v = 8'((idx - GreyFirstIdx) * 10 + 8);
    return {v, v, v};
  endfunction

  function automatic int unsigned sq_dist(input logic [7:0] a, input logic [7:0] b);
    int unsigned d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  // Ascending scan, strict improvement only, stop on a close enough match.
  function automatic logic [7:0] nearest_index(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int unsigned best;
    int unsigned cand_dist;
    int unsigned idx;
    logic [7:0]  best_idx;
    logic [23:0] c;
    bit          stop;
    best     = FarDist;
    best_idx = 8'd0;
    stop     = 1'b0;
    for (idx = 0; idx < 256 && !stop; idx++) begin
      if (idx != SkipLoIdx && idx != SkipHiIdx) begin
        c         = palette_rgb(idx);
        cand_dist = RedWeight * sq_dist(r, c[23:16]) + GreenWeight * sq_dist(g, c[15:8]) +
                    sq_dist(b, c[7:0]);
        if (cand_dist < best) begin
          best     = cand_dist;
          best_idx = 8'(idx);
          stop     = (cand_dist < CloseDist);
        end
      end
    end
    return best_idx;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_index_q.push_back(nearest_index(r, g, b));
    @(negedge clk_i);
  endtask

  task automatic test_extremes();
    send_color(8'h00, 8'h00, 8'h00);
    send_color(8'hff, 8'hff, 8'hff);
    send_color(8'hff, 8'h00, 8'h00);
    send_color(8'h00, 8'hff, 8'h00);
    send_color(8'h00, 8'h00, 8'hff);
    send_color(8'hff, 8'hff, 8'h00);
    send_color(8'h00, 8'hff, 8'hff);
    send_color(8'hff, 8'h00, 8'hff);
    send_color(8'h55, 8'haa, 8'h55);
    send_color(8'haa, 8'h55, 8'haa);
  endtask

  task automatic test_special_colors();
    // skipped cube corners: black and white, also owned by system entries
    send_color(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd255, 8'd255);
    // exact grey and exact cube hits
    send_color(8'd8, 8'd8, 8'd8);
    send_color(8'd95, 8'd135, 8'd175);
    // distance 30 exits, distance 31 keeps scanning
    send_color(8'd95, 8'd136, 8'd175);
    send_color(8'd95, 8'd136, 8'd176);
    // early exit on a system entry; the nearest grey lies farther away
    send_color(8'd128, 8'd127, 8'd128);
    send_color(8'd229, 8'd229, 8'd228);
    // tie between two greys, lower index wins; then an exact system entry hit
    send_color(8'd13, 8'd13, 8'd13);
    send_color(8'h5c, 8'h5c, 8'hff);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct);
    int unsigned n;
    int unsigned pick;
    logic [23:0] c;
    logic [7:0]  v;
    sender_idle_pct = idle_pct;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_color(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        c = palette_rgb($urandom_range(0, 255));
        send_color(jitter(c[23:16]), jitter(c[15:8]), jitter(c[7:0]));
      end else begin
        v = 8'($urandom);
        send_color(v, jitter(v), jitter(v));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_index_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d", $time,
                 palette_index_o);
        mismatch_cnt++;
      end else begin
        want_index = expected_index_q.pop_front();
        if (palette_index_o !== want_index) begin
          $display("%0t: palette_index mismatch: expected %0d, actual %0d", $time,
                   want_index, palette_index_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("nearest_palette_color_search_test: errors");
      $finish;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    red_i   = 8'd0;
    green_i = 8'd0;
    blue_i  = 8'd0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    sender_idle_pct = 21;
    test_extremes();
    test_special_colors();
    test_random(360, 21);
    test_random(360, 58);
    test_random(360, 0);
    start <= 1'b0;
    while (expected_index_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("nearest_palette_color_search_test: clean");
    end else begin
      $display("nearest_palette_color_search_test: errors");
    end
    $finish;
  end

endmodule
